>>> hw/rtl/mwr_pkg.sv
// ----------------------------------------------------------------------------
// mwr_pkg
// Shared constants, types and helpers of the moving-window RMS block.
// ----------------------------------------------------------------------------
package mwr_pkg;

  localparam int WINDOW      = 1500;
  localparam int SAMPLE_BITS = 16;

  localparam int FIELD_W = 16;
  localparam int OUT_W   = 16;
  localparam int TDATA_W = 2 * FIELD_W;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUM_W  = $clog2(WINDOW + 1) + 2 * SAMPLE_BITS - 2;
  localparam int Q_W    = 2 * SAMPLE_BITS - 1;

  // restoring divider by the window length, several quotient bits per cycle
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W      = DIV_CYCLES * DIV_STEPS;
  localparam int REM_W      = $clog2(WINDOW) + 1;

  // digit-by-digit square root, one root bit per cycle
  localparam int R_W   = (Q_W + 1) / 2;
  localparam int RAD_W = 2 * R_W;
  localparam int SR_W  = R_W + 1;
  localparam int ST_W  = R_W + 3;

  localparam int ITER_MAX = (DIV_CYCLES > R_W) ? DIV_CYCLES : R_W;
  localparam int CNT_W    = $clog2(ITER_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } mwr_state_t;

  typedef struct packed {
    logic              sample_load;
    logic              square_en;
    logic              sum_en;
    logic              div_en;
    logic              div_last;
    logic              sqrt_en;
    logic              evict_valid;
    logic [SLOT_W-1:0] slot;
  } lane_ctrl_t;

  function automatic logic [SAMPLE_BITS-1:0] sample_mag(input logic [SAMPLE_BITS-1:0] s);
    sample_mag = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
  endfunction

  function automatic logic [SQ_W-1:0] square_of(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] m;
    m = sample_mag(s);
    square_of = SQ_W'(m) * SQ_W'(m);
  endfunction

endpackage

>>> hw/rtl/mwr_ram.sv
// ----------------------------------------------------------------------------
// mwr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mwr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1500
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mwr_lane.sv
// ----------------------------------------------------------------------------
// mwr_lane
// One lane: sample window, running sum of squares, divide by window, root.
// ----------------------------------------------------------------------------
module mwr_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  mwr_pkg::lane_ctrl_t          ctrl,
  input  logic [mwr_pkg::FIELD_W-1:0]  field,
  output logic [mwr_pkg::OUT_W-1:0]    rms
);

  import mwr_pkg::*;

  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] evicted;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic [FIELD_W+SAMPLE_BITS-1:0] field_wide;
  logic [SQ_W-1:0]        old_sq;
  logic [SQ_W-1:0]        new_sq;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       sum_next;
  logic [DIV_W-1:0]       dq;
  logic [DIV_W-1:0]       dq_next;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_next;
  logic [RAD_W-1:0]       rad;
  logic [SR_W-1:0]        srem;
  logic [SR_W-1:0]        srem_next;
  logic [R_W-1:0]         root;
  logic [R_W-1:0]         root_next;
  logic [R_W+OUT_W-1:0]   root_wide;

  // sample is the low SAMPLE_BITS of the field
  assign field_wide = {{SAMPLE_BITS{1'b0}}, field};
  assign sample_in  = field_wide[SAMPLE_BITS-1:0];

  mwr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ctrl.square_en),
    .waddr (ctrl.slot),
    .wdata (sample),
    .raddr (ctrl.slot),
    .rdata (rd_data)
  );

  // slots not yet written since reset are read as zero until the window is full
  assign evicted  = ctrl.evict_valid ? rd_data : '0;
  assign sum_next = sum - SUM_W'(old_sq) + SUM_W'(new_sq);

  always_ff @(posedge clk) begin
    if (ctrl.sample_load) begin
      sample <= sample_in;
    end
    if (ctrl.square_en) begin
      old_sq <= square_of(evicted);
      new_sq <= square_of(sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.sum_en) begin
      sum <= sum_next;
    end
  end

  // restoring division by WINDOW, DIV_STEPS quotient bits per cycle
  always_comb begin
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] t;
    logic [DIV_W-1:0] d;
    r = rem;
    d = dq;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r[REM_W-2:0], d[DIV_W-1]};
      d = {d[DIV_W-2:0], 1'b0};
      if (t >= REM_W'(WINDOW)) begin
        r    = t - REM_W'(WINDOW);
        d[0] = 1'b1;
      end else begin
        r = t;
      end
    end
    rem_next = r;
    dq_next  = d;
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      dq  <= DIV_W'(sum_next);
      rem <= '0;
    end else if (ctrl.div_en) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  // one root bit per cycle, two radicand bits consumed per step
  always_comb begin
    logic [ST_W-1:0] t;
    logic [ST_W-1:0] trial;
    t     = {srem, rad[RAD_W-1:RAD_W-2]};
    trial = {1'b0, root, 2'b01};
    if (t >= trial) begin
      srem_next = SR_W'(t - trial);
      root_next = {root[R_W-2:0], 1'b1};
    end else begin
      srem_next = SR_W'(t);
      root_next = {root[R_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_last) begin
      rad  <= RAD_W'(dq_next[Q_W-1:0]);
      srem <= '0;
      root <= '0;
    end else if (ctrl.sqrt_en) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      srem <= srem_next;
      root <= root_next;
    end
  end

  // saturate a root too wide for the output
  assign root_wide = {{OUT_W{1'b0}}, root};
  assign rms = (root_wide > {{R_W{1'b0}}, {OUT_W{1'b1}}}) ? '1 : root_wide[OUT_W-1:0];

endmodule

>>> hw/rtl/mwr_ctrl.sv
// ----------------------------------------------------------------------------
// mwr_ctrl
// Sequencer shared by both lanes: slot pointer, fill flag and step counter.
// ----------------------------------------------------------------------------
module mwr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 out_free,
  output logic                 out_load,
  output mwr_pkg::lane_ctrl_t  lane_ctrl
);

  import mwr_pkg::*;

  mwr_state_t        state;
  mwr_state_t        state_next;
  logic [SLOT_W-1:0] slot;
  logic              full;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              div_done;
  logic              sqrt_done;

  assign div_done  = (cnt == CNT_W'(DIV_CYCLES - 1));
  assign sqrt_done = (cnt == CNT_W'(R_W - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready              = 1'b0;
    out_load              = 1'b0;
    cnt_next              = '0;
    lane_ctrl             = '0;
    lane_ctrl.slot        = slot;
    lane_ctrl.evict_valid = full;
    case (state)
      ST_IDLE: begin
        s_tready              = 1'b1;
        lane_ctrl.sample_load = s_tvalid;
      end
      ST_READ: lane_ctrl.square_en = 1'b1;
      ST_SUM:  lane_ctrl.sum_en = 1'b1;
      ST_DIV: begin
        lane_ctrl.div_en   = 1'b1;
        lane_ctrl.div_last = div_done;
        cnt_next           = div_done ? '0 : cnt + 1'b1;
      end
      ST_SQRT: begin
        lane_ctrl.sqrt_en = 1'b1;
        cnt_next          = sqrt_done ? '0 : cnt + 1'b1;
      end
      ST_DONE: out_load = out_free;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      slot  <= '0;
      full  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      // advance the oldest slot once the new sample has been written
      if (state == ST_READ) begin
        if (slot == SLOT_W'(WINDOW - 1)) begin
          slot <= '0;
          full <= 1'b1;
        end else begin
          slot <= slot + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(WINDOW - 1))
    else $error("slot pointer beyond window");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("fill flag dropped without reset");

  a_slot_moves_after_write: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(slot)) |-> ($past(state) == ST_READ))
    else $error("slot pointer moved outside the write cycle");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt < CNT_W'(DIV_CYCLES)))
    else $error("divider step count overran");
`endif

endmodule

>>> hw/rtl/moving_window_rms_top.sv
// ----------------------------------------------------------------------------
// moving_window_rms_top
// Sliding-window RMS of two signed error lanes (x and y), Q3.12 in, unsigned Q4.12 out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transfer carries err_x and err_y. Output stream m_*:
//   one transfer per input carries rms_x and rms_y, the truncated integer root
//   of the mean square over the last WINDOW samples of each lane.
//   Both lanes run side by side on a shared sequencer; each lane reads the
//   evicted sample from its window RAM, updates its running sum of squares,
//   divides by WINDOW (DIV_STEPS quotient bits per cycle) and takes the root
//   one bit per cycle.
//   s_tready is high only while the sequencer is idle, so a new input is
//   accepted only after the previous one has gone through the read, sum,
//   divide, root and done states and the sequencer is back in idle.
//   A finished result waits in the output register while the next item is
//   accepted and worked on; if the receiver still stalls when that item is
//   done, the sequencer holds it until the register frees.
//   Reset: synchronous, active high. Clears the sums, the slot pointer and
//   the fill flag; window slots not yet written since reset count as zero.
// ----------------------------------------------------------------------------
module moving_window_rms_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [mwr_pkg::TDATA_W-1:0]  s_tdata,   // err_x [15:0], err_y [31:16]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [mwr_pkg::TDATA_W-1:0]  m_tdata    // rms_x [15:0], rms_y [31:16]
);

  import mwr_pkg::*;

  lane_ctrl_t       lane_ctrl;
  logic             out_free;
  logic             out_load;
  logic [OUT_W-1:0] rms_x;
  logic [OUT_W-1:0] rms_y;

  // the output register is free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  mwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .out_free  (out_free),
    .out_load  (out_load),
    .lane_ctrl (lane_ctrl)
  );

  mwr_lane u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lane_ctrl),
    .field (s_tdata[FIELD_W-1:0]),
    .rms   (rms_x)
  );

  mwr_lane u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lane_ctrl),
    .field (s_tdata[2*FIELD_W-1:FIELD_W]),
    .rms   (rms_y)
  );

  // merge both lane results into one output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {rms_y, rms_x};
    end
  end

endmodule
